/* hdl/ifmf_pkg.sv */
// Shared types, codes and helpers for the IPv4 first-match rule filter.
package ifmf_pkg;

  localparam int unsigned ProtoW  = 2;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned UseW    = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;

  localparam logic [ProtoW-1:0] PROTO_ANY = 2'd2;
  localparam logic [ProtoW-1:0] PROTO_BAD = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_BLOCK = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RULES_IN_USE  = 1'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic              verdict;
    logic [ProtoW-1:0] proto;
    logic              host_any;
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  mask;
    logic              port_any;
    logic [PortW-1:0]  port_lo;
    logic [PortW-1:0]  port_hi;
  } rule_t;

  localparam int unsigned RuleW = $bits(rule_t);

  typedef enum logic [1:0] {
    PEND_ZERO    = 2'd0,
    PEND_DEFAULT = 2'd1,
    PEND_RULE    = 2'd2
  } pend_sel_e;

  typedef struct packed {
    logic      accept;
    logic      scan_step;
    logic      pend_load;
    pend_sel_e pend_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic short_check;
    logic slot_match;
    logic scan_last;
  } sts_t;

  // Fold the unused code onto "any".
  function automatic logic [ProtoW-1:0] norm_proto(input logic [ProtoW-1:0] p);
    norm_proto = (p == PROTO_BAD) ? PROTO_ANY : p;
  endfunction

endpackage

/* hdl/ifmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ifmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ifmf_ctrl.sv */
// Sequencer for the rule filter: accept, slot scan and result handoff.
module ifmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ifmf_pkg::sts_t    sts_i,
  output ifmf_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.pend_sel = ifmf_pkg::PEND_ZERO;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.is_check) begin
            cmd_o.pend_load = 1'b1;
            cmd_o.pend_sel  = ifmf_pkg::PEND_ZERO;
            state_d         = ST_DONE;
          end else if (sts_i.short_check) begin
            cmd_o.pend_load = 1'b1;
            cmd_o.pend_sel  = ifmf_pkg::PEND_DEFAULT;
            state_d         = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.slot_match) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_sel  = ifmf_pkg::PEND_RULE;
          state_d         = ST_DONE;
        end else if (sts_i.scan_last) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pend_sel  = ifmf_pkg::PEND_DEFAULT;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/ifmf_dp.sv */
// Datapath of the rule filter: config registers, rule RAM, slot compare, result registers.
module ifmf_dp #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ifmf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ifmf_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                               action_i,
  input  logic [ifmf_pkg::SlotW-1:0]         rule_slot_i,
  input  logic                               rule_blocks_i,
  input  logic [ifmf_pkg::ProtoW-1:0]        protocol_i,
  input  logic                               host_any_i,
  input  logic [ifmf_pkg::AddrW-1:0]         ipv4_addr_i,
  input  logic [ifmf_pkg::AddrW-1:0]         ipv4_mask_i,
  input  logic                               port_any_i,
  input  logic [ifmf_pkg::PortW-1:0]         port_lo_i,
  input  logic [ifmf_pkg::PortW-1:0]         port_hi_i,
  input  logic                               ipv6_query_i,
  input  ifmf_pkg::cmd_t                     cmd_i,
  output ifmf_pkg::sts_t                     sts_o,
  output logic                               blocked_o,
  output logic                               rule_hit_o,
  output logic [ifmf_pkg::SlotW-1:0]         hit_slot_o
);

  localparam int unsigned IdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(RULE_SLOTS + 1);
  localparam int unsigned LimW = (CntW > ifmf_pkg::UseW) ? CntW : ifmf_pkg::UseW;

  logic                        default_block_q;
  logic [ifmf_pkg::UseW-1:0]   rules_in_use_q;

  logic [LimW-1:0]             limit;
  logic                        slot_ok;
  logic                        ram_we;
  logic [IdxW-1:0]             waddr;
  logic [IdxW-1:0]             raddr;
  ifmf_pkg::rule_t             wrule;
  ifmf_pkg::rule_t             rrule;

  logic [IdxW-1:0]             idx_q, idx_d;
  logic [ifmf_pkg::ProtoW-1:0] q_proto_q;
  logic [ifmf_pkg::AddrW-1:0]  q_addr_q;
  logic [ifmf_pkg::PortW-1:0]  q_port_q;

  logic                        proto_ok, host_ok, port_ok;

  logic                        pend_blocked_q, pend_blocked_d;
  logic                        pend_hit_q, pend_hit_d;
  logic [ifmf_pkg::SlotW-1:0]  pend_slot_q, pend_slot_d;

  logic                        blocked_q;
  logic                        rule_hit_q;
  logic [ifmf_pkg::SlotW-1:0]  hit_slot_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_block_q <= 1'b0;
      rules_in_use_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifmf_pkg::CFG_DEFAULT_BLOCK: default_block_q <= cfg_data_i[0];
        ifmf_pkg::CFG_RULES_IN_USE:  rules_in_use_q  <= cfg_data_i[ifmf_pkg::UseW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the active count to the table depth.
  assign limit = (LimW'(rules_in_use_q) > LimW'(RULE_SLOTS)) ? LimW'(RULE_SLOTS)
                                                              : LimW'(rules_in_use_q);

  // Rule write; drop slots past the table.
  assign slot_ok = LimW'(rule_slot_i) < LimW'(RULE_SLOTS);
  assign ram_we  = cmd_i.accept && (action_i == ifmf_pkg::ACT_WRITE) && slot_ok;
  assign waddr   = IdxW'(rule_slot_i);

  always_comb begin
    wrule.verdict  = rule_blocks_i;
    wrule.proto    = ifmf_pkg::norm_proto(protocol_i);
    wrule.host_any = host_any_i;
    wrule.addr     = ipv4_addr_i;
    wrule.mask     = ipv4_mask_i;
    wrule.port_any = port_any_i;
    wrule.port_lo  = port_lo_i;
    wrule.port_hi  = port_hi_i;
  end

  // Prefetch the next slot while the current one is compared.
  assign raddr = (cmd_i.scan_step && !sts_o.scan_last) ? idx_q + IdxW'(1) : '0;

  ifmf_ram #(
    .Width (ifmf_pkg::RuleW),
    .Depth (RULE_SLOTS)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wrule),
    .raddr_i (raddr),
    .rdata_o (rrule)
  );

  // Query capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      q_proto_q <= ifmf_pkg::norm_proto(protocol_i);
      q_addr_q  <= ipv4_addr_i;
      q_port_q  <= port_lo_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.scan_step) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Slot compare.
  assign proto_ok = (rrule.proto == ifmf_pkg::PROTO_ANY) || (rrule.proto == q_proto_q);
  assign host_ok  = rrule.host_any || (((q_addr_q ^ rrule.addr) & rrule.mask) == '0);
  assign port_ok  = rrule.port_any ||
                    ((q_port_q >= rrule.port_lo) && (q_port_q <= rrule.port_hi));

  assign sts_o.is_check    = (action_i == ifmf_pkg::ACT_CHECK);
  assign sts_o.short_check = ipv6_query_i || (limit == '0);
  assign sts_o.slot_match  = proto_ok && host_ok && port_ok;
  assign sts_o.scan_last   = (LimW'(idx_q) + LimW'(1)) == limit;

  // Pending result.
  always_comb begin
    pend_blocked_d = pend_blocked_q;
    pend_hit_d     = pend_hit_q;
    pend_slot_d    = pend_slot_q;
    if (cmd_i.pend_load) begin
      case (cmd_i.pend_sel)
        ifmf_pkg::PEND_DEFAULT: begin
          pend_blocked_d = default_block_q;
          pend_hit_d     = 1'b0;
          pend_slot_d    = '0;
        end
        ifmf_pkg::PEND_RULE: begin
          pend_blocked_d = rrule.verdict;
          pend_hit_d     = 1'b1;
          pend_slot_d    = ifmf_pkg::SlotW'(idx_q);
        end
        default: begin
          pend_blocked_d = 1'b0;
          pend_hit_d     = 1'b0;
          pend_slot_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pend_blocked_q <= pend_blocked_d;
    pend_hit_q     <= pend_hit_d;
    pend_slot_q    <= pend_slot_d;
    if (cmd_i.out_load) begin
      blocked_q  <= pend_blocked_q;
      rule_hit_q <= pend_hit_q;
      hit_slot_q <= pend_slot_q;
    end
  end

  assign blocked_o  = blocked_q;
  assign rule_hit_o = rule_hit_q;
  assign hit_slot_o = hit_slot_q;

endmodule

/* hdl/ipv4_first_match_rule_filter.sv */
// Top level of the IPv4 first-match rule filter.
// First-match IPv4 rule filter. A write transaction stores one rule into a slot of a
// RULE_SLOTS-deep RAM. A check transaction walks slots 0 up to rules_in_use-1
// (clamped to RULE_SLOTS) one per cycle through the single RAM read port and stops
// at the first match; the table is skipped for an IPv6 query or when no slots are
// active. One transaction is in flight at a time; the result register lets the next
// input be taken while a result waits on the output. Configure only while idle; rule
// slots read before being written return unspecified fields.
module ipv4_first_match_rule_filter #(
  parameter int unsigned RULE_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ifmf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ifmf_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [ifmf_pkg::SlotW-1:0]    rule_slot_i,
  input  logic                          rule_blocks_i,
  input  logic [ifmf_pkg::ProtoW-1:0]   protocol_i,
  input  logic                          host_any_i,
  input  logic [ifmf_pkg::AddrW-1:0]    ipv4_addr_i,
  input  logic [ifmf_pkg::AddrW-1:0]    ipv4_mask_i,
  input  logic                          port_any_i,
  input  logic [ifmf_pkg::PortW-1:0]    port_lo_i,
  input  logic [ifmf_pkg::PortW-1:0]    port_hi_i,
  input  logic                          ipv6_query_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          blocked_o,
  output logic                          rule_hit_o,
  output logic [ifmf_pkg::SlotW-1:0]    hit_slot_o
);

  ifmf_pkg::cmd_t cmd;
  ifmf_pkg::sts_t sts;

  ifmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ifmf_dp #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .rule_slot_i   (rule_slot_i),
    .rule_blocks_i (rule_blocks_i),
    .protocol_i    (protocol_i),
    .host_any_i    (host_any_i),
    .ipv4_addr_i   (ipv4_addr_i),
    .ipv4_mask_i   (ipv4_mask_i),
    .port_any_i    (port_any_i),
    .port_lo_i     (port_lo_i),
    .port_hi_i     (port_hi_i),
    .ipv6_query_i  (ipv6_query_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .blocked_o     (blocked_o),
    .rule_hit_o    (rule_hit_o),
    .hit_slot_o    (hit_slot_o)
  );

endmodule
